// ===== design/polygon_keepout_test_macros.svh =====
// Assertion macros used by the checker file of the keep-out polygon test.
`ifndef POLYGON_KEEPOUT_TEST_MACROS_SVH
`define POLYGON_KEEPOUT_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pkt_pkg.sv =====
// Types, codes and fixed widths of the keep-out polygon test.
package pkt_pkg;

    localparam int COORD_W  = 24;
    localparam int MARGIN_W = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SPLIT    = 26;
    localparam int HI_W     = SUM_W - SPLIT;
    localparam int M2_W     = 2 * MARGIN_W;
    localparam int CR_W     = 2 * SUM_W;
    localparam int RR_W     = M2_W + SUM_W;
    localparam int BOX_W    = COORD_W + 2;
    localparam int VTX_W    = 2 * COORD_W;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd256;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_SHORT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOX,
        S_READ,
        S_LAST,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic                      closes_region;
    } t_in;

    typedef struct packed {
        logic       forbidden;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [M2_W-1:0]           m2;
        logic                      mnz;
    } t_edge_req;

    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
        logic flip;
    } t_edge_res;

endpackage

// ===== design/pkt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pkt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pkt_edge.sv =====
// Six-stage pipeline that tests one polygon edge against the query point.
module pkt_edge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pkt_pkg::t_edge_req i_req,
    output pkt_pkg::t_edge_res o_res
);
    import pkt_pkg::*;

    logic [5:0] r_v;

    // Stage 1: differences and the crossing condition.
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_ax, r1_ay, r1_bx, r1_by;
    logic r1_yc;
    // Stage 2: products.
    logic signed [PROD_W-1:0] r2_dxdx, r2_dydy, r2_axdx, r2_aydy, r2_axdy, r2_aydx;
    logic signed [PROD_W-1:0] r2_axax, r2_ayay, r2_bxbx, r2_byby, r2_lhs, r2_rhs;
    logic r2_yc, r2_dpos;
    // Stage 3: sums.
    logic signed [SUM_W-1:0] r3_len2, r3_dot, r3_cross, r3_d2a, r3_d2b;
    logic r3_flip;
    // Stage 4: case selection.
    logic [SUM_W-1:0] r4_ac, r4_len2;
    logic r4_pt, r4_on_pt, r4_near_pt, r4_on_cr, r4_flip;
    // Stage 5: partial products of the squared cross product and the bound.
    logic [2*HI_W-1:0]       r5_hh;
    logic [HI_W+SPLIT-1:0]   r5_hl;
    logic [2*SPLIT-1:0]      r5_ll;
    logic [M2_W+HI_W-1:0]    r5_rh;
    logic [M2_W+SPLIT-1:0]   r5_rl;
    logic r5_pt, r5_on_pt, r5_near_pt, r5_on_cr, r5_flip;
    // Stage 6: full-width terms.
    logic [CR_W-1:0] r6_cr2;
    logic [RR_W-1:0] r6_rr;
    logic r6_pt, r6_on_pt, r6_near_pt, r6_on_cr, r6_flip;

    logic w_near_cr, w_on, w_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx <= DIFF_W'(i_req.ex) - DIFF_W'(i_req.sx);
        r1_dy <= DIFF_W'(i_req.ey) - DIFF_W'(i_req.sy);
        r1_ax <= DIFF_W'(i_req.px) - DIFF_W'(i_req.sx);
        r1_ay <= DIFF_W'(i_req.py) - DIFF_W'(i_req.sy);
        r1_bx <= DIFF_W'(i_req.px) - DIFF_W'(i_req.ex);
        r1_by <= DIFF_W'(i_req.py) - DIFF_W'(i_req.ey);
        r1_yc <= (i_req.ey > i_req.py) != (i_req.sy > i_req.py);

        r2_dxdx <= r1_dx * r1_dx;
        r2_dydy <= r1_dy * r1_dy;
        r2_axdx <= r1_ax * r1_dx;
        r2_aydy <= r1_ay * r1_dy;
        r2_axdy <= r1_ax * r1_dy;
        r2_aydx <= r1_ay * r1_dx;
        r2_axax <= r1_ax * r1_ax;
        r2_ayay <= r1_ay * r1_ay;
        r2_bxbx <= r1_bx * r1_bx;
        r2_byby <= r1_by * r1_by;
        r2_lhs  <= r1_bx * (-r1_dy);
        r2_rhs  <= (-r1_dx) * r1_by;
        r2_yc   <= r1_yc;
        r2_dpos <= r1_dy < 0;

        r3_len2  <= SUM_W'(r2_dxdx) + SUM_W'(r2_dydy);
        r3_dot   <= SUM_W'(r2_axdx) + SUM_W'(r2_aydy);
        r3_cross <= SUM_W'(r2_axdy) - SUM_W'(r2_aydx);
        r3_d2a   <= SUM_W'(r2_axax) + SUM_W'(r2_ayay);
        r3_d2b   <= SUM_W'(r2_bxbx) + SUM_W'(r2_byby);
        r3_flip  <= r2_yc && (r2_dpos ? (r2_lhs < r2_rhs) : (r2_lhs > r2_rhs));

        // The nearest point is an end vertex unless the foot of the
        // perpendicular falls strictly inside the edge.
        r4_pt      <= (r3_dot <= 0) || (r3_dot >= r3_len2);
        r4_on_pt   <= ((r3_dot <= 0) ? r3_d2a : r3_d2b) == '0;
        r4_near_pt <= $unsigned((r3_dot <= 0) ? r3_d2a : r3_d2b) <= SUM_W'(i_req.m2);
        r4_ac      <= r3_cross[SUM_W-1] ? $unsigned(-r3_cross) : $unsigned(r3_cross);
        r4_on_cr   <= r3_cross == '0;
        r4_len2    <= $unsigned(r3_len2);
        r4_flip    <= r3_flip;

        r5_hh <= r4_ac[SUM_W-1:SPLIT] * r4_ac[SUM_W-1:SPLIT];
        r5_hl <= r4_ac[SUM_W-1:SPLIT] * r4_ac[SPLIT-1:0];
        r5_ll <= r4_ac[SPLIT-1:0] * r4_ac[SPLIT-1:0];
        r5_rh <= i_req.m2 * r4_len2[SUM_W-1:SPLIT];
        r5_rl <= i_req.m2 * r4_len2[SPLIT-1:0];
        r5_pt      <= r4_pt;
        r5_on_pt   <= r4_on_pt;
        r5_near_pt <= r4_near_pt;
        r5_on_cr   <= r4_on_cr;
        r5_flip    <= r4_flip;

        r6_cr2 <= (CR_W'(r5_hh) << (2 * SPLIT)) + (CR_W'(r5_hl) << (SPLIT + 1))
                  + CR_W'(r5_ll);
        r6_rr  <= (RR_W'(r5_rh) << SPLIT) + RR_W'(r5_rl);
        r6_pt      <= r5_pt;
        r6_on_pt   <= r5_on_pt;
        r6_near_pt <= r5_near_pt;
        r6_on_cr   <= r5_on_cr;
        r6_flip    <= r5_flip;
    end

    assign w_near_cr = r6_cr2 <= CR_W'(r6_rr);
    assign w_on      = r6_pt ? r6_on_pt : r6_on_cr;
    assign w_near    = r6_pt ? r6_near_pt : w_near_cr;

    assign o_res.busy  = |r_v;
    assign o_res.valid = r_v[5];
    assign o_res.hit   = w_on || (i_req.mnz && w_near);
    assign o_res.flip  = r6_flip;

endmodule

// ===== design/polygon_keepout_test.sv =====
// Top level of the keep-out polygon test: region store, query sequencer, output register.
//
// Usage. Items arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in) and each one yields exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out). A clear or an append goes from
// the transfer through S_RESULT to the output register. A query walks the
// closed regions in order: a region whose margin-grown box misses the point
// is skipped in S_BOX, any other has its vertices read from the vertex
// memory at one vertex per cycle and its edges sent through the six-stage
// edge pipeline, which drains before the region's verdict is taken. A query
// stops at the first forbidding region. One item is worked on at a time; the input
// is ready again once its result sits in the output register, so a stalled receiver
// holds the result there and the block still accepts the next item, which then
// waits for the register to be taken. Reset (synchronous, active low) empties the
// store and sets the margin to 256; the margin is written on i_cfg_we, which the
// user must raise only while idle; the block itself does not enforce this.
module polygon_keepout_test #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_REGIONS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pkt_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pkt_pkg::t_out                    o_out,
    input  logic                             i_cfg_we,
    input  logic [pkt_pkg::MARGIN_W-1:0]     i_cfg_data
);
    import pkt_pkg::*;

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    t_state r_state, n_state;

    logic [MARGIN_W-1:0] r_margin;
    logic [CW-1:0]       r_regions_used;
    logic [VC-1:0]       r_vertices_used;
    logic [VC-1:0]       r_open_start;

    // Bounding box of the region being built; it is copied on close.
    logic signed [COORD_W-1:0] r_ob_min_x, r_ob_max_x, r_ob_min_y, r_ob_max_y;

    // Per-region descriptors of the closed regions.
    logic [VA-1:0]             r_reg_first [MAX_REGIONS];
    logic [VC-1:0]             r_reg_count [MAX_REGIONS];
    logic signed [COORD_W-1:0] r_reg_min_x [MAX_REGIONS];
    logic signed [COORD_W-1:0] r_reg_max_x [MAX_REGIONS];
    logic signed [COORD_W-1:0] r_reg_min_y [MAX_REGIONS];
    logic signed [COORD_W-1:0] r_reg_max_y [MAX_REGIONS];

    // Query context.
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [M2_W-1:0]           r_m2;
    logic [RW-1:0]             r_qr;
    logic [VA-1:0]             r_rd_addr;
    logic [VC-1:0]             r_rd_left;
    logic                      r_rd_valid, r_rd_first;
    logic signed [COORD_W-1:0] r_v0x, r_v0y, r_pvx, r_pvy;
    logic                      r_hit, r_par;

    t_out r_res, r_out;
    logic r_out_valid;

    logic            w_in_accept, w_full, w_short, w_last_region, w_box_miss;
    logic [VC-1:0]   w_n;
    logic            c_ram_re, c_region_start, c_qr_next;
    logic [VA-1:0]   c_ram_raddr;
    logic            w_ram_we;
    logic [VTX_W-1:0] w_rdata;
    logic signed [COORD_W-1:0] w_rx, w_ry;
    logic signed [COORD_W-1:0] w_nb_min_x, w_nb_max_x, w_nb_min_y, w_nb_max_y;
    logic signed [BOX_W-1:0]   w_px_e, w_py_e, w_m_e;
    t_edge_req w_req;
    t_edge_res w_res;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;

    // Append bookkeeping.
    assign w_full  = (r_regions_used >= CW'(MAX_REGIONS))
                  || (r_vertices_used >= VC'(MAX_VERTICES));
    assign w_n     = r_vertices_used - r_open_start + VC'(1);
    assign w_short = i_in.closes_region && (w_n < VC'(3));
    assign w_ram_we = w_in_accept && (i_in.action == ACT_APPEND) && !w_full;

    always_comb begin
        if (w_n == VC'(1)) begin
            w_nb_min_x = i_in.coord_x;
            w_nb_max_x = i_in.coord_x;
            w_nb_min_y = i_in.coord_y;
            w_nb_max_y = i_in.coord_y;
        end else begin
            w_nb_min_x = (i_in.coord_x < r_ob_min_x) ? i_in.coord_x : r_ob_min_x;
            w_nb_max_x = (i_in.coord_x > r_ob_max_x) ? i_in.coord_x : r_ob_max_x;
            w_nb_min_y = (i_in.coord_y < r_ob_min_y) ? i_in.coord_y : r_ob_min_y;
            w_nb_max_y = (i_in.coord_y > r_ob_max_y) ? i_in.coord_y : r_ob_max_y;
        end
    end

    // Box test of the current query region, grown by the margin.
    assign w_px_e = BOX_W'(r_px);
    assign w_py_e = BOX_W'(r_py);
    assign w_m_e  = $signed({{(BOX_W - MARGIN_W){1'b0}}, r_margin});
    assign w_box_miss = (w_px_e + w_m_e < BOX_W'(r_reg_min_x[r_qr]))
                     || (w_px_e - w_m_e > BOX_W'(r_reg_max_x[r_qr]))
                     || (w_py_e + w_m_e < BOX_W'(r_reg_min_y[r_qr]))
                     || (w_py_e - w_m_e > BOX_W'(r_reg_max_y[r_qr]));
    assign w_last_region = (CW'(r_qr) + CW'(1)) == r_regions_used;

    // Vertex memory: x in the upper half, y in the lower half.
    pkt_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_vertices_used[VA-1:0]),
        .i_wdata ({i_in.coord_x, i_in.coord_y}),
        .i_re    (c_ram_re),
        .i_raddr (c_ram_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rx = $signed(w_rdata[VTX_W-1:COORD_W]);
    assign w_ry = $signed(w_rdata[COORD_W-1:0]);

    // Edges run from the previous vertex to the one just read; the closing
    // edge runs from the last vertex back to the first.
    assign w_req.valid = (r_rd_valid && !r_rd_first) || (r_state == S_LAST);
    assign w_req.sx    = r_pvx;
    assign w_req.sy    = r_pvy;
    assign w_req.ex    = (r_state == S_LAST) ? r_v0x : w_rx;
    assign w_req.ey    = (r_state == S_LAST) ? r_v0y : w_ry;
    assign w_req.px    = r_px;
    assign w_req.py    = r_py;
    assign w_req.m2    = r_m2;
    assign w_req.mnz   = r_margin != '0;

    pkt_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // Sequencer: next state and memory read strobes.
    always_comb begin
        n_state        = r_state;
        c_ram_re       = 1'b0;
        c_ram_raddr    = r_rd_addr;
        c_region_start = 1'b0;
        c_qr_next      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    if (i_in.action == ACT_QUERY && r_regions_used != '0) begin
                        n_state = S_BOX;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_BOX: begin
                if (w_box_miss) begin
                    if (w_last_region) begin
                        n_state = S_RESULT;
                    end else begin
                        c_qr_next = 1'b1;
                    end
                end else begin
                    n_state        = S_READ;
                    c_ram_re       = 1'b1;
                    c_ram_raddr    = r_reg_first[r_qr];
                    c_region_start = 1'b1;
                end
            end
            S_READ: begin
                if (r_rd_left != '0) begin
                    c_ram_re = 1'b1;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!w_res.busy) begin
                    if (r_hit || r_par || w_last_region) begin
                        n_state = S_RESULT;
                    end else begin
                        c_qr_next = 1'b1;
                        n_state   = S_BOX;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_margin        <= MARGIN_RESET;
            r_regions_used  <= '0;
            r_vertices_used <= '0;
            r_open_start    <= '0;
            r_rd_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= c_ram_re;
            if (i_cfg_we) begin
                r_margin <= i_cfg_data;
            end
            if (w_in_accept && i_in.action == ACT_CLEAR) begin
                r_regions_used  <= '0;
                r_vertices_used <= '0;
                r_open_start    <= '0;
            end else if (w_ram_we) begin
                if (w_short) begin
                    r_vertices_used <= r_open_start;
                end else begin
                    r_vertices_used <= r_vertices_used + VC'(1);
                    if (i_in.closes_region) begin
                        r_regions_used <= r_regions_used + CW'(1);
                        r_open_start   <= r_vertices_used + VC'(1);
                    end
                end
            end
            if (r_state == S_RESULT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_ram_we) begin
            r_ob_min_x <= w_nb_min_x;
            r_ob_max_x <= w_nb_max_x;
            r_ob_min_y <= w_nb_min_y;
            r_ob_max_y <= w_nb_max_y;
            if (i_in.closes_region && !w_short) begin
                r_reg_first[r_regions_used[RW-1:0]] <= r_open_start[VA-1:0];
                r_reg_count[r_regions_used[RW-1:0]] <= w_n;
                r_reg_min_x[r_regions_used[RW-1:0]] <= w_nb_min_x;
                r_reg_max_x[r_regions_used[RW-1:0]] <= w_nb_max_x;
                r_reg_min_y[r_regions_used[RW-1:0]] <= w_nb_min_y;
                r_reg_max_y[r_regions_used[RW-1:0]] <= w_nb_max_y;
            end
        end

        if (w_in_accept) begin
            r_px    <= i_in.coord_x;
            r_py    <= i_in.coord_y;
            r_m2    <= M2_W'(r_margin) * M2_W'(r_margin);
            r_qr    <= '0;
            r_res.forbidden <= 1'b0;
            if (i_in.action == ACT_APPEND) begin
                r_res.status <= w_full ? STAT_FULL : (w_short ? STAT_SHORT : STAT_OK);
            end else begin
                r_res.status <= STAT_OK;
            end
        end else if (c_qr_next) begin
            r_qr <= r_qr + RW'(1);
        end

        if (r_state == S_DRAIN && !w_res.busy) begin
            r_res.forbidden <= r_hit || r_par;
        end

        if (c_region_start) begin
            r_rd_addr  <= r_reg_first[r_qr] + VA'(1);
            r_rd_left  <= r_reg_count[r_qr] - VC'(1);
            r_rd_first <= 1'b1;
            r_hit      <= 1'b0;
            r_par      <= 1'b0;
        end else begin
            if (c_ram_re) begin
                r_rd_addr <= r_rd_addr + VA'(1);
                r_rd_left <= r_rd_left - VC'(1);
            end
            if (r_rd_valid) begin
                r_rd_first <= 1'b0;
            end
            if (w_res.valid) begin
                r_hit <= r_hit || w_res.hit;
                r_par <= r_par ^ w_res.flip;
            end
        end

        if (r_rd_valid) begin
            r_pvx <= w_rx;
            r_pvy <= w_ry;
            if (r_rd_first) begin
                r_v0x <= w_rx;
                r_v0y <= w_ry;
            end
        end

        if (r_state == S_RESULT && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/pkt_checker.sv =====
// Port-level checker of the keep-out polygon test and its bind to the top level.
`include "polygon_keepout_test_macros.svh"

module pkt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input pkt_pkg::t_in                 i_in,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input pkt_pkg::t_out                o_out,
    input logic                         i_cfg_we,
    input logic [pkt_pkg::MARGIN_W-1:0] i_cfg_data
);
    import pkt_pkg::*;

    // A forbidden verdict only comes from a query, which always reports ok.
    `PKT_ASSERT_NOW(a_forbid_ok, i_clk, i_rst_n, o_out_valid && o_out.forbidden, o_out.status == STAT_OK, "forbidden result carries a nonzero status")

    // Items are worked on one at a time: a transfer closes the input.
    `PKT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transfer")

    // A result that is not taken stays put.
    `PKT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

endmodule

bind polygon_keepout_test pkt_checker u_pkt_checker (.*);

// ===== dv/tb_polygon_keepout_test.sv =====
// Self-checking testbench of the keep-out polygon test block.
`timescale 1ns / 1ps

module tb_polygon_keepout_test;
    import pkt_pkg::*;

    localparam int NVERT = 64;
    localparam int NREG  = 8;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_in          i_in;
    logic         o_out_valid;
    logic         i_out_ready;
    t_out         o_out;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_data;

    polygon_keepout_test #(.MAX_VERTICES(NVERT), .MAX_REGIONS(NREG)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the block's state, kept by the predictor.
    logic [15:0]        shadow_margin;
    longint             vx [NVERT];
    longint             vy [NVERT];
    int                 reg_first [NREG];
    int                 reg_count [NREG];
    longint             bx_lo [NREG], bx_hi [NREG], by_lo [NREG], by_hi [NREG];
    int                 regions_used, vertices_used;

    t_out   verdicts_due [$];
    int     error_count;
    int     transfers_in, transfers_out, forbidden_seen;
    int     send_idle_pct, recv_idle_pct;
    bit     recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The cross product squared can exceed 64 bits, so these checks use 128-bit math.
    function automatic bit seg_near(longint px, longint py, longint sx, longint sy,
                                    longint ex, longint ey, longint m, output bit on);
        longint dx, dy, ax, ay, len2, dot, d2, cr;
        logic signed [127:0] c2, r2;
        dx = ex - sx; dy = ey - sy; ax = px - sx; ay = py - sy;
        len2 = dx * dx + dy * dy;
        dot = ax * dx + ay * dy;
        if (len2 == 0 || dot <= 0) begin
            d2 = ax * ax + ay * ay;
            on = (d2 == 0);
            return d2 <= m * m;
        end
        if (dot >= len2) begin
            d2 = (px - ex) * (px - ex) + (py - ey) * (py - ey);
            on = (d2 == 0);
            return d2 <= m * m;
        end
        cr = ax * dy - ay * dx;
        on = (cr == 0);
        c2 = 128'(cr) * 128'(cr);
        r2 = 128'(m * m) * 128'(len2);
        return c2 <= r2;
    endfunction

    function automatic bit region_hits(int r, longint px, longint py, longint m);
        bit in_poly, on, near;
        int i, j, n, f;
        longint d, lhs, rhs;
        in_poly = 0;
        f = reg_first[r];
        n = reg_count[r];
        if (px < bx_lo[r] - m || px > bx_hi[r] + m || py < by_lo[r] - m || py > by_hi[r] + m)
            return 0;
        for (int k = 0; k < n; k++) begin
            i = f + k;
            j = f + ((k == 0) ? n - 1 : k - 1);
            near = seg_near(px, py, vx[j], vy[j], vx[i], vy[i], m, on);
            if (on || (m > 0 && near)) return 1;
            if ((vy[i] > py) != (vy[j] > py)) begin
                d = vy[j] - vy[i];
                lhs = (px - vx[i]) * d;
                rhs = (vx[j] - vx[i]) * (py - vy[i]);
                if (d > 0 ? lhs < rhs : lhs > rhs) in_poly = !in_poly;
            end
        end
        return in_poly;
    endfunction

    // Advances the shadow state by one item and returns the verdict it should produce.
    function automatic t_out predict_verdict(t_in it);
        t_out   res;
        longint x, y;
        int     r, start, n;
        res = '0;
        x = longint'(it.coord_x);
        y = longint'(it.coord_y);
        case (it.action)
            ACT_CLEAR: begin
                regions_used = 0;
                vertices_used = 0;
            end
            ACT_APPEND: begin
                r = regions_used;
                if (r >= NREG || vertices_used >= NVERT) begin
                    res.status = STAT_FULL;
                end else begin
                    start = (r == 0) ? 0 : reg_first[r-1] + reg_count[r-1];
                    n = vertices_used - start + 1;
                    vx[vertices_used] = x;
                    vy[vertices_used] = y;
                    if (n == 1) begin
                        bx_lo[r] = x; bx_hi[r] = x; by_lo[r] = y; by_hi[r] = y;
                    end else begin
                        if (x < bx_lo[r]) bx_lo[r] = x;
                        if (x > bx_hi[r]) bx_hi[r] = x;
                        if (y < by_lo[r]) by_lo[r] = y;
                        if (y > by_hi[r]) by_hi[r] = y;
                    end
                    reg_first[r] = start;
                    reg_count[r] = n;
                    vertices_used++;
                    if (it.closes_region) begin
                        if (n < 3) begin
                            vertices_used = start;
                            res.status = STAT_SHORT;
                        end else begin
                            regions_used++;
                        end
                    end
                end
            end
            ACT_QUERY: begin
                for (int q = 0; q < regions_used; q++) begin
                    if (region_hits(q, x, y, longint'(shadow_margin))) begin
                        res.forbidden = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one item at the falling edge and holds it until the transfer happens.
    // Valid stays high after the transfer; the next call or an idle phase lowers it.
    task automatic send_item(t_in it);
        t_out want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        want = predict_verdict(it);
        verdicts_due = {verdicts_due, want};
        do @(posedge i_clk); while (!o_in_ready);
        transfers_in++;
        @(negedge i_clk);
    endtask

    function automatic t_in make_item(logic [1:0] a, int x, int y, bit c);
        t_in it;
        it.action = a;
        it.coord_x = x[23:0];
        it.coord_y = y[23:0];
        it.closes_region = c;
        return it;
    endfunction

    // Waits for all verdicts plus the query latency before touching the margin.
    task automatic write_margin(logic [15:0] value);
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (700) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        shadow_margin = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int rand_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // One random item: mostly polygon appends around the origin and queries, with a few clears and odd actions.
    task automatic random_item(int span, ref int open_n);
        int   kind, cx, cy;
        bit   c;
        kind = $urandom_range(99);
        if (kind < 3) begin
            send_item(make_item(ACT_CLEAR, $urandom, $urandom, 1'($urandom_range(1))));
            open_n = 0;
        end else if (kind < 5) begin
            send_item(make_item(2'd3, $urandom, $urandom, 1'($urandom_range(1))));
        end else if (kind < 50) begin
            c = (open_n >= 2 + $urandom_range(4)) || ($urandom_range(30) == 0);
            send_item(make_item(ACT_APPEND, rand_coord(span), rand_coord(span), c));
            open_n = c ? 0 : open_n + 1;
        end else if (kind < 53) begin
            send_item(make_item(2'($urandom_range(2)), $urandom, $urandom,
                                1'($urandom_range(1))));
        end else begin
            cx = rand_coord(span + 300);
            cy = rand_coord(span + 300);
            send_item(make_item(ACT_QUERY, cx, cy, 1'($urandom_range(1))));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                recv_hold = 0;
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checker: every result is matched against the oldest pending verdict.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            transfers_out++;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result forbidden=%0d status=%0d", $time,
                         o_out.forbidden, o_out.status);
                error_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_out.forbidden !== want.forbidden) begin
                    $display("%0t: forbidden mismatch expected %0d actual %0d", $time,
                             want.forbidden, o_out.forbidden);
                    error_count++;
                end
                if (o_out.status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             want.status, o_out.status);
                    error_count++;
                end
                if (o_out.forbidden) forbidden_seen++;
            end
        end
    end

    typedef struct {
        logic [1:0] action;
        int         x;
        int         y;
        bit         closes;
        bit         typed;
        t_out       want;
    } t_row;

    t_row directed [$];

    task automatic add_row(logic [1:0] a, int x, int y, bit c, bit typed, bit f, logic [1:0] s);
        t_row r;
        r.action = a; r.x = x; r.y = y; r.closes = c; r.typed = typed;
        r.want.forbidden = f; r.want.status = s;
        directed = {directed, r};
    endtask

    initial begin
        t_in it;
        t_out p;
        int   open_n, guard;
        int   phase_span [4];
        logic [15:0] phase_margin [4];
        error_count = 0; transfers_in = 0; transfers_out = 0; forbidden_seen = 0;
        recv_hold = 0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        shadow_margin = MARGIN_RESET;
        regions_used = 0;
        vertices_used = 0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: empty-store query, short region, a square, extremes,
        // open-region vertices, zero-length edges, unknown action and a clear.
        add_row(ACT_QUERY, 0, 0, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 5, 5, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 9, 9, 1, 1, 0, STAT_SHORT);
        add_row(ACT_APPEND, 0, 0, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 2560, 0, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 2560, 2560, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 0, 2560, 1, 1, 0, STAT_OK);
        add_row(ACT_QUERY, 1280, 1280, 0, 1, 1, STAT_OK);
        add_row(ACT_QUERY, 2560, 1000, 0, 1, 1, STAT_OK);
        add_row(ACT_QUERY, 2816, 1000, 0, 0, 0, STAT_OK);
        add_row(ACT_QUERY, 2817, 1000, 0, 1, 0, STAT_OK);
        add_row(ACT_QUERY, -200, -200, 0, 0, 0, STAT_OK);
        add_row(ACT_APPEND, -8388608, -8388608, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, -8388608, -8388608, 0, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 8388607, -8388608, 0, 1, 0, STAT_OK);
        add_row(ACT_QUERY, 8388607, -8388608, 1, 1, 0, STAT_OK);
        add_row(ACT_APPEND, 8388607, 8388607, 1, 1, 0, STAT_OK);
        add_row(ACT_QUERY, 8388607, 8388607, 1, 1, 1, STAT_OK);
        add_row(ACT_QUERY, -8388608, 8388607, 0, 0, 0, STAT_OK);
        add_row(ACT_QUERY, 0, -8388608, 0, 1, 1, STAT_OK);
        add_row(2'd3, -1, -1, 1, 1, 0, STAT_OK);
        add_row(ACT_CLEAR, -1, -1, 1, 1, 0, STAT_OK);
        add_row(ACT_QUERY, 1280, 1280, 0, 1, 0, STAT_OK);
        foreach (directed[i]) begin
            it = make_item(directed[i].action, directed[i].x, directed[i].y, directed[i].closes);
            send_item(it);
            if (directed[i].typed) begin
                p = verdicts_due[$];
                if (p !== directed[i].want) begin
                    $display("%0t: directed row %0d expected %0d/%0d predictor %0d/%0d",
                             $time, i, directed[i].want.forbidden, directed[i].want.status,
                             p.forbidden, p.status);
                    error_count++;
                end
            end
        end

        // Random phases across margins, coordinate spans and idling patterns.
        phase_margin = '{16'd0, 16'hFFFF, 16'd37, 16'd1000};
        phase_span   = '{3000, 60000, 8388607, 2000};
        open_n = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_margin(phase_margin[ph]);
            case (ph)
                0: begin send_idle_pct = 23; recv_idle_pct = 84; end
                1: begin send_idle_pct = 84; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 400; n++) begin
                if (ph == 2 && n == 50) recv_hold = 1;
                random_item(phase_span[ph], open_n);
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (verdicts_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (700) @(negedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, verdicts_due.size());
            error_count++;
        end
        $display("Sent %0d items, checked %0d results, %0d forbidden verdicts,", transfers_in,
                 transfers_out, forbidden_seen);
        $display("over four margins with sender and receiver stalls and a long hold-off.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
